[rtl/ptpo_pkg.sv]
// Shared types and constants for the price-time priority order list.
package ptpo_pkg;

    // Default number of order slots in the table.
    localparam int CAPACITY_DEF = 64;

    // Field widths of the stream payloads.
    localparam int MODE_W   = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Packed payload widths, rounded up to whole bytes.
    localparam int IN_BITS  = MODE_W + 3 * WORD_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STATUS_W + 1 + 3 * WORD_W + COUNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Operation codes carried in the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_POP    = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic load;
    } ptpo_cmd_t;

endpackage

[rtl/price_time_priority_order_list.sv]
// Top level of the price-time priority order list.
//
// One side of an order book held as a sorted table of CAPACITY orders, best
// order first: highest price on the buy side (side = 0), lowest on the sell
// side (side = 1), earlier timestamp first at equal price, and an exact tie
// placed after the orders already held. Each input transfer inserts, removes
// the first order with a given id, pops the head or clears the table, and
// yields exactly one result transfer with the status, the head order and the
// count. The item is compared against every table cell in parallel during the
// cycle of its input transfer and registered with it; the next cycle shifts
// the cells and the result state then loads the output register once it is
// free. The next item is taken the cycle after the result enters the output
// register, so the block takes no new item before the last result is loaded;
// a result held by a stalled output delays the load and with it the next
// input transfer. The user must write the side register only while the block
// is idle; the block itself does not enforce it.
module price_time_priority_order_list #(
    parameter int CAPACITY = ptpo_pkg::CAPACITY_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Side register write port.
    input  logic                         side_we,
    input  logic                         side_wdata,
    // Input stream.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // mode[1:0], order_id[33:2], order_price[65:34], order_time[97:66], zero pad
    input  logic [ptpo_pkg::IN_W-1:0]    s_tdata,
    // Result stream.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // status[1:0], head_valid[2], head_id[34:3], head_price[66:35],
    // head_time[98:67], order_count[105:99], zero pad
    output logic [ptpo_pkg::OUT_W-1:0]   m_tdata
);
    import ptpo_pkg::*;

    ptpo_cmd_t cmd;

    ptpo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ptpo_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .side_we    (side_we),
        .side_wdata (side_wdata),
        .in_mode    (s_tdata[MODE_W-1:0]),
        .in_id      (s_tdata[MODE_W +: WORD_W]),
        .in_price   (s_tdata[MODE_W + WORD_W +: WORD_W]),
        .in_time    (s_tdata[MODE_W + 2 * WORD_W +: WORD_W]),
        .result     (m_tdata)
    );

endmodule

[rtl/ptpo_datapath.sv]
// Datapath of the order list: sorted entry cells, compare vectors and result register.
module ptpo_datapath #(
    parameter int CAPACITY = ptpo_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ptpo_pkg::ptpo_cmd_t               cmd,
    input  logic                              side_we,
    input  logic                              side_wdata,
    input  logic [ptpo_pkg::MODE_W-1:0]       in_mode,
    input  logic [ptpo_pkg::WORD_W-1:0]       in_id,
    input  logic [ptpo_pkg::WORD_W-1:0]       in_price,
    input  logic [ptpo_pkg::WORD_W-1:0]       in_time,
    output logic [ptpo_pkg::OUT_W-1:0]        result
);
    import ptpo_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Configuration and item registers.
    logic                  side_reg;
    mode_t                 mode_reg;
    logic [WORD_W-1:0]     id_reg;
    logic [WORD_W-1:0]     price_reg;
    logic [WORD_W-1:0]     time_reg;

    // Sorted table, best order in cell 0.
    logic [WORD_W-1:0]     ent_id_reg    [CAPACITY];
    logic [WORD_W-1:0]     ent_price_reg [CAPACITY];
    logic [WORD_W-1:0]     ent_time_reg  [CAPACITY];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;

    // Per-cell compare results, registered at capture.
    logic [CAPACITY-1:0]   ahead_next;
    logic [CAPACITY-1:0]   ahead_reg;
    logic [CAPACITY-1:0]   match_next;
    logic [CAPACITY-1:0]   match_reg;

    // Update selection vectors.
    logic [CAPACITY-1:0]   ins_low;
    logic [CAPACITY-1:0]   ins_below;
    logic [CAPACITY-1:0]   low_bit;
    logic [CAPACITY-1:0]   below_hit;
    logic [CAPACITY-1:0]   shift_vec;
    logic                  ins_en;
    logic                  full;
    logic                  found;

    logic [OUT_W-1:0]      result_reg;

    // Side register, written over the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= 1'b0;
        end
        else if (side_we)
        begin
            side_reg <= side_wdata;
        end
    end

    // Each cell compares the incoming order against its own entry.
    // Cells past the fill level count as beaten so the insert point is their first.
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cmp
        logic cell_valid;
        logic price_better;
        assign cell_valid   = count_reg > CNT_W'(k);
        assign price_better = side_reg ? (in_price < ent_price_reg[k])
                                       : (in_price > ent_price_reg[k]);
        assign ahead_next[k] = !cell_valid ||
                               ((in_price != ent_price_reg[k]) ? price_better
                                                               : (in_time < ent_time_reg[k]));
        assign match_next[k] = cell_valid && (in_id == ent_id_reg[k]);
    end

    // Latch the accepted item and its compare vectors.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= mode_t'(in_mode);
            id_reg    <= in_id;
            price_reg <= in_price;
            time_reg  <= in_time;
            ahead_reg <= ahead_next;
            match_reg <= match_next;
        end
    end

    // The lowest set cell of a vector is isolated with a two's complement trick.
    // After a side change the table need not be sorted for the new side, so the
    // insert point is the first beaten cell and every cell above it takes the one below.
    // For a removal every cell from the lowest match upward takes its upper neighbor.
    assign full       = count_reg == CNT_W'(CAPACITY);
    assign found      = |match_reg;
    assign low_bit    = match_reg & (~match_reg + CAPACITY'(1));
    assign below_hit  = low_bit - CAPACITY'(1);
    assign ins_low    = ahead_reg & (~ahead_reg + CAPACITY'(1));
    assign ins_below  = ins_low - CAPACITY'(1);
    assign ins_en     = cmd.update && (mode_reg == MODE_INSERT) && !full;

    always_comb
    begin
        shift_vec   = '0;
        count_next  = count_reg;
        status_next = ST_DONE;
        unique case (mode_reg)
            MODE_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_REMOVE:
            begin
                if (found)
                begin
                    shift_vec  = ~below_hit;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            MODE_POP:
            begin
                if (count_reg != '0)
                begin
                    shift_vec  = '1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            MODE_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Count and status registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= ST_DONE;
        end
        else if (cmd.update)
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // Cell update: an insert opens a gap at the first beaten cell and pushes
    // the rest down; a removal closes the gap by pulling the rest up.
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic take_new;
        logic take_prev;
        logic take_next;
        assign take_new  = ins_en && ins_low[k];
        assign take_prev = ins_en && !ins_below[k] && !ins_low[k];
        assign take_next = cmd.update && shift_vec[k];

        always_ff @(posedge clk)
        begin
            if (take_new)
            begin
                ent_id_reg[k]    <= id_reg;
                ent_price_reg[k] <= price_reg;
                ent_time_reg[k]  <= time_reg;
            end
            else if (take_prev)
            begin
                if (k > 0)
                begin
                    ent_id_reg[k]    <= ent_id_reg[(k > 0) ? k - 1 : 0];
                    ent_price_reg[k] <= ent_price_reg[(k > 0) ? k - 1 : 0];
                    ent_time_reg[k]  <= ent_time_reg[(k > 0) ? k - 1 : 0];
                end
            end
            else if (take_next)
            begin
                if (k < CAPACITY - 1)
                begin
                    ent_id_reg[k]    <= ent_id_reg[(k < CAPACITY - 1) ? k + 1 : k];
                    ent_price_reg[k] <= ent_price_reg[(k < CAPACITY - 1) ? k + 1 : k];
                    ent_time_reg[k]  <= ent_time_reg[(k < CAPACITY - 1) ? k + 1 : k];
                end
            end
        end
    end

    // Result register: status, head order and count after the update.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (count_reg != '0)
            begin
                result_reg <= OUT_W'({COUNT_W'(count_reg), ent_time_reg[0],
                                      ent_price_reg[0], ent_id_reg[0], 1'b1, status_reg});
            end
            else
            begin
                result_reg <= OUT_W'({COUNT_W'(count_reg), {(3 * WORD_W){1'b0}},
                                      1'b0, status_reg});
            end
        end
    end

    assign result = result_reg;

endmodule

[rtl/ptpo_ctrl.sv]
// Controller of the order list: sequences capture, update and result transfer.
module ptpo_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output ptpo_pkg::ptpo_cmd_t  cmd
);
    import ptpo_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_RESULT
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    // The output register is free once its result has been taken.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        cmd.capture = s_tvalid && s_tready_reg;
        cmd.update  = state_reg == S_UPDATE;
        cmd.load    = (state_reg == S_RESULT) && out_free;
    end

    // State and handshake registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // A new result takes the output register even as the old one leaves.
            if (cmd.load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready_reg)
                    begin
                        s_tready_reg <= 1'b0;
                        state_reg    <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        s_tready_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule
